// File: rtl/vcvpd_pkg.sv
// ----------------------------------------------------------------------------
// vcvpd_pkg
// Shared types, register indexes, port offsets and helpers for the VRAM
// port and DMA core.
// ----------------------------------------------------------------------------
package vcvpd_pkg;

   typedef logic [1:0]  offset_type;
   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;
   typedef logic [4:0]  regsel_type;

   // access direction
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // port offsets
   localparam offset_type OFS_SELECT  = 2'd0;
   localparam offset_type OFS_UNUSED  = 2'd1;
   localparam offset_type OFS_DATA_LO = 2'd2;
   localparam offset_type OFS_DATA_HI = 2'd3;

   // register indexes that carry behavior
   localparam regsel_type REG_VRAM_WR_ADDR = 5'h00;
   localparam regsel_type REG_VRAM_RD_ADDR = 5'h01;
   localparam regsel_type REG_VRAM_DATA    = 5'h02;
   localparam regsel_type REG_STEP         = 5'h05;
   localparam regsel_type REG_DMA_CTL      = 5'h0F;
   localparam regsel_type REG_DMA_SRC      = 5'h10;
   localparam regsel_type REG_DMA_DST      = 5'h11;
   localparam regsel_type REG_DMA_LEN      = 5'h12;

   // DMA control bits in register 0x0F
   localparam int DMA_CTL_IRQ_EN   = 1;
   localparam int DMA_CTL_SRC_DOWN = 2;
   localparam int DMA_CTL_DST_DOWN = 3;

   localparam int       DMA_LEN_BITS    = 15;
   localparam int       STATUS_DONE_BIT = 4;
   localparam byte_type RDATA_NONE      = 8'hFF;
   localparam byte_type STEP_RESET      = 8'd1;

   typedef logic [DMA_LEN_BITS-1:0] dma_len_type;

   // controller to datapath
   typedef struct packed {
      logic latch;       // capture the accepted request
      logic clear;       // write one zero word of the clearing pass
      logic exec;        // decode and apply the latched request
      logic rd_capture;  // VRAM read data is on the RAM output
      logic dma_rd;      // present the DMA source address
      logic dma_wr;      // write the DMA destination word
      logic push;        // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_vram_read;
      logic is_dma_start;
      logic dma_last;
      logic clear_last;
   } sts_type;

   // step size chosen by bits 4..3 of the high byte written to register 5
   function automatic byte_type step_lookup(input logic [1:0] code);
      byte_type step;
      unique case (code)
         2'd0:    step = 8'd1;
         2'd1:    step = 8'd32;
         2'd2:    step = 8'd64;
         default: step = 8'd128;
      endcase
      return step;
   endfunction

   // replace one byte of a register word
   function automatic word_type set_byte(input word_type w, input byte_type b,
                                         input logic hi);
      word_type r;
      r = hi ? {b, w[7:0]} : {w[15:8], b};
      return r;
   endfunction

endpackage

// File: rtl/vcvpd_ifs.sv
// ----------------------------------------------------------------------------
// vcvpd request and response channels
// Valid/ready channels carrying one bus access and its result.
// ----------------------------------------------------------------------------
interface vcvpd_req_if;
   import vcvpd_pkg::*;

   logic       valid;
   logic       ready;
   logic       mode;
   offset_type offset;
   byte_type   wdata;

   modport source (output valid, mode, offset, wdata, input ready);
   modport sink   (input valid, mode, offset, wdata, output ready);
endinterface

interface vcvpd_rsp_if;
   import vcvpd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rdata;
   logic     irq_line;

   modport source (output valid, rdata, irq_line, input ready);
   modport sink   (input valid, rdata, irq_line, output ready);
endinterface

// File: rtl/vcvpd_ram.sv
// ----------------------------------------------------------------------------
// vcvpd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vcvpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/vcvpd_ctrl.sv
// ----------------------------------------------------------------------------
// vcvpd_ctrl
// Sequencer: clearing pass, request decode, VRAM read wait, DMA loop and
// response handoff.
// ----------------------------------------------------------------------------
module vcvpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  vcvpd_pkg::sts_type sts,
   output vcvpd_pkg::cmd_type cmd
);
   import vcvpd_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_RDWAIT = 3'd3;
   localparam logic [2:0] ST_DMA_RD = 3'd4;
   localparam logic [2:0] ST_DMA_WR = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.latch      = accept;
      cmd.clear      = (state_ff == ST_CLEAR);
      cmd.exec       = (state_ff == ST_EXEC);
      cmd.rd_capture = (state_ff == ST_RDWAIT);
      cmd.dma_rd     = (state_ff == ST_DMA_RD);
      cmd.dma_wr     = (state_ff == ST_DMA_WR);
      cmd.push       = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            priority if (sts.is_vram_read) state_in = ST_RDWAIT;
            else if (sts.is_dma_start)     state_in = ST_DMA_RD;
            else                           state_in = ST_FINISH;
         end
         ST_RDWAIT: state_in = ST_FINISH;
         ST_DMA_RD: state_in = ST_DMA_WR;
         ST_DMA_WR: state_in = sts.dma_last ? ST_FINISH : ST_DMA_RD;
         ST_FINISH: if (out_free) state_in = accept ? ST_EXEC : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.push) rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/vcvpd_dpath.sv
// ----------------------------------------------------------------------------
// vcvpd_dpath
// Register file, address and DMA counters, VRAM instance and response
// payload register.
// ----------------------------------------------------------------------------
module vcvpd_dpath #(
   parameter int VRAM_ADDR_BITS = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_mode,
   input  vcvpd_pkg::offset_type req_offset,
   input  vcvpd_pkg::byte_type   req_wdata,
   input  vcvpd_pkg::cmd_type    cmd,
   output vcvpd_pkg::sts_type    sts,
   output vcvpd_pkg::byte_type   rsp_rdata,
   output logic                  rsp_irq_line
);
   import vcvpd_pkg::*;

   localparam int AW = VRAM_ADDR_BITS;

   // latched request
   logic       mode_ff, mode_in;
   offset_type offset_ff, offset_in;
   byte_type   wdata_ff, wdata_in;

   // architectural state
   regsel_type sel_ff, sel_in;
   word_type   reg0_ff, reg0_in, reg1_ff, reg1_in;
   word_type   reg0f_ff, reg0f_in, reg10_ff, reg10_in;
   word_type   reg11_ff, reg11_in, reg12_ff, reg12_in;
   byte_type   step_ff, step_in;
   byte_type   low_hold_ff, low_hold_in;
   logic       done_ff, done_in, irq_ff, irq_in;

   // DMA, clearing pass and result
   logic [AW-1:0] src_ff, src_in, dst_ff, dst_in;
   dma_len_type   cnt_ff, cnt_in;
   logic [AW-1:0] clear_ff, clear_in;
   byte_type      result_ff, result_in;
   byte_type      out_rdata_ff, out_rdata_in;
   logic          out_irq_ff, out_irq_in;

   // VRAM port
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   word_type      ram_wdata, ram_rdata;

   logic     is_hi, is_data_ofs;
   word_type step_word;

   assign is_hi       = (offset_ff == OFS_DATA_HI);
   assign is_data_ofs = (offset_ff == OFS_DATA_LO) || (offset_ff == OFS_DATA_HI);
   assign step_word   = {8'h00, step_ff};

   assign sts.is_vram_read = (mode_ff == MODE_READ) && is_data_ofs && (sel_ff == REG_VRAM_DATA);
   assign sts.is_dma_start = (mode_ff == MODE_WRITE) && is_hi && (sel_ff == REG_DMA_LEN);
   assign sts.dma_last     = (cnt_ff == '0);
   assign sts.clear_last   = &clear_ff;

   always_comb begin
      mode_in      = mode_ff;
      offset_in    = offset_ff;
      wdata_in     = wdata_ff;
      sel_in       = sel_ff;
      reg0_in      = reg0_ff;
      reg1_in      = reg1_ff;
      reg0f_in     = reg0f_ff;
      reg10_in     = reg10_ff;
      reg11_in     = reg11_ff;
      reg12_in     = reg12_ff;
      step_in      = step_ff;
      low_hold_in  = low_hold_ff;
      done_in      = done_ff;
      irq_in       = irq_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      cnt_in       = cnt_ff;
      clear_in     = clear_ff;
      result_in    = result_ff;
      out_rdata_in = out_rdata_ff;
      out_irq_in   = out_irq_ff;
      ram_we       = 1'b0;
      ram_waddr    = reg0_ff[AW-1:0];
      ram_wdata    = {wdata_ff, low_hold_ff};
      ram_raddr    = reg1_ff[AW-1:0];

      if (cmd.latch) begin
         mode_in   = req_mode;
         offset_in = req_offset;
         wdata_in  = req_wdata;
      end

      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clear_ff;
         ram_wdata = '0;
         clear_in  = clear_ff + 1'b1;
      end

      if (cmd.exec) begin
         result_in = RDATA_NONE;
         if (mode_ff == MODE_READ) begin
            if (offset_ff == OFS_SELECT) begin
               // status read: report, then drop done and interrupt
               result_in                  = '0;
               result_in[STATUS_DONE_BIT] = done_ff;
               done_in                    = 1'b0;
               irq_in                     = 1'b0;
            end
         end else if (offset_ff == OFS_SELECT) begin
            sel_in = wdata_ff[4:0];
         end else if (is_data_ofs) begin
            case (sel_ff)
               REG_VRAM_WR_ADDR: reg0_in  = set_byte(reg0_ff, wdata_ff, is_hi);
               REG_VRAM_RD_ADDR: reg1_in  = set_byte(reg1_ff, wdata_ff, is_hi);
               REG_DMA_CTL:      reg0f_in = set_byte(reg0f_ff, wdata_ff, is_hi);
               REG_DMA_SRC:      reg10_in = set_byte(reg10_ff, wdata_ff, is_hi);
               REG_DMA_DST:      reg11_in = set_byte(reg11_ff, wdata_ff, is_hi);
               REG_DMA_LEN:      reg12_in = set_byte(reg12_ff, wdata_ff, is_hi);
               default:          ;
            endcase
            if (sel_ff == REG_VRAM_DATA) begin
               if (is_hi) begin
                  ram_we  = 1'b1;
                  reg0_in = reg0_ff + step_word;
               end else begin
                  low_hold_in = wdata_ff;
               end
            end
            if ((sel_ff == REG_STEP) && is_hi) begin
               step_in = step_lookup(wdata_ff[4:3]);
            end
            if (sts.is_dma_start) begin
               src_in = reg10_ff[AW-1:0];
               dst_in = reg11_ff[AW-1:0];
               cnt_in = dma_len_type'({wdata_ff, reg12_ff[7:0]});
            end
         end
      end

      if (cmd.rd_capture) begin
         result_in = is_hi ? ram_rdata[15:8] : ram_rdata[7:0];
         if (is_hi) begin
            reg1_in = reg1_ff + step_word;
         end
      end

      if (cmd.dma_rd) begin
         ram_raddr = src_ff;
      end

      if (cmd.dma_wr) begin
         ram_we    = 1'b1;
         ram_waddr = dst_ff;
         ram_wdata = ram_rdata;
         src_in    = reg0f_ff[DMA_CTL_SRC_DOWN] ? src_ff - 1'b1 : src_ff + 1'b1;
         dst_in    = reg0f_ff[DMA_CTL_DST_DOWN] ? dst_ff - 1'b1 : dst_ff + 1'b1;
         cnt_in    = cnt_ff - 1'b1;
         if (sts.dma_last) begin
            done_in = 1'b1;
            if (reg0f_ff[DMA_CTL_IRQ_EN]) begin
               irq_in = 1'b1;
            end
         end
      end

      if (cmd.push) begin
         out_rdata_in = result_ff;
         out_irq_in   = irq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff      <= '0;
         reg0_ff     <= '0;
         reg1_ff     <= '0;
         reg0f_ff    <= '0;
         reg10_ff    <= '0;
         reg11_ff    <= '0;
         reg12_ff    <= '0;
         step_ff     <= STEP_RESET;
         low_hold_ff <= '0;
         done_ff     <= 1'b0;
         irq_ff      <= 1'b0;
         clear_ff    <= '0;
      end else begin
         sel_ff      <= sel_in;
         reg0_ff     <= reg0_in;
         reg1_ff     <= reg1_in;
         reg0f_ff    <= reg0f_in;
         reg10_ff    <= reg10_in;
         reg11_ff    <= reg11_in;
         reg12_ff    <= reg12_in;
         step_ff     <= step_in;
         low_hold_ff <= low_hold_in;
         done_ff     <= done_in;
         irq_ff      <= irq_in;
         clear_ff    <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      offset_ff    <= offset_in;
      wdata_ff     <= wdata_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      cnt_ff       <= cnt_in;
      result_ff    <= result_in;
      out_rdata_ff <= out_rdata_in;
      out_irq_ff   <= out_irq_in;
   end

   vcvpd_ram #(
      .WIDTH (16),
      .DEPTH (1 << VRAM_ADDR_BITS)
   ) u_vram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_rdata    = out_rdata_ff;
   assign rsp_irq_line = out_irq_ff;

endmodule

// File: rtl/video_ctrl_vram_port_dma_core.sv
// ----------------------------------------------------------------------------
// video_ctrl_vram_port_dma_core
// CPU byte port of a video controller: register select, VRAM word access
// through the data register and VRAM-to-VRAM block DMA.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                 handshake
//   req_chan  in         mode, offset, wdata     valid / ready
//   rsp_chan  out        rdata, irq_line         valid / ready
//
// Every accepted request gives exactly one response.
// After reset the core clears VRAM, one word a cycle, through all
// 2^VRAM_ADDR_BITS words; req_chan.ready stays low during that pass.
// A register or status access passes the EXEC and FINISH states; a VRAM read
// adds RDWAIT between them, as the single VRAM read port has registered data.
// A DMA trigger copies length+1 words, each in a DMA_RD and a DMA_WR state:
// each word costs one RAM read and one RAM write over the VRAM ports.
// A finished response waits in the output register; the next request is
// accepted meanwhile and stalls only at its own handoff while rsp_chan is held.
//
module video_ctrl_vram_port_dma_core #(
   parameter int VRAM_ADDR_BITS = 15
) (
   input logic         clock,
   input logic         reset,
   vcvpd_req_if.sink   req_chan,
   vcvpd_rsp_if.source rsp_chan
);
   import vcvpd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: owns handshake and response valid
   vcvpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: registers, VRAM, DMA counters, response payload
   vcvpd_dpath #(
      .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_chan.mode),
      .req_offset   (req_chan.offset),
      .req_wdata    (req_chan.wdata),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_rdata    (rsp_chan.rdata),
      .rsp_irq_line (rsp_chan.irq_line)
   );

endmodule

// File: rtl/vcvpd_checker.sv
// ----------------------------------------------------------------------------
// vcvpd_checker
// Port-level checks for the VRAM port and DMA core, bound to the top level.
// ----------------------------------------------------------------------------
module vcvpd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input vcvpd_pkg::byte_type rsp_rdata,
   input logic                rsp_irq_line
);
   import vcvpd_pkg::*;

   // requests accepted and not yet answered
   logic [1:0] open_ff, open_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (req_fire && !rsp_fire) open_in = open_ff + 2'd1;
      if (rsp_fire && !req_fire) open_in = open_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rdata) && $stable(rsp_irq_line))
      else $error("response dropped or changed while stalled");

   // reset starts the clearing pass with nothing to deliver
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("core not quiet after reset");

   // no response without an open request
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without request");

   // at most one request in work plus one waiting response; the next
   // request may only enter while the waiting response leaves
   a_depth: assert property (@(posedge clock) disable iff (reset)
      open_ff == 2'd2 && !rsp_ready |-> !req_ready)
      else $error("too many requests in flight");

endmodule

bind video_ctrl_vram_port_dma_core vcvpd_checker u_vcvpd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_rdata    (rsp_chan.rdata),
   .rsp_irq_line (rsp_chan.irq_line)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: VRAM port and DMA core testbench
// Drives byte bus accesses into the core over the request channel and checks
// every response against a cycle-free model of the port. A short table of
// directed accesses runs first. Random sequences follow, mostly VRAM bursts,
// address setup and DMA runs. The sender idles in bursts, and the receiver
// stalls in phases of its own.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vcvpd_pkg::*;

   localparam int VRAM_ADDR_BITS = 15;
   localparam int VRAM_WORDS     = 1 << VRAM_ADDR_BITS;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int BIG_DMA_RUNS   = 3;
   // a full-length DMA copies 2^15 words, each with a read and a write, after
   // a clearing pass over all 2^15 VRAM words
   localparam int STALL_LIMIT    = 300000;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct packed {
      byte_type rdata;
      logic     irq;
   } port_reply_type;

   // one row of the directed table; fixed rows carry their reply typed in
   typedef struct packed {
      logic       mode;
      offset_type ofs;
      byte_type   data;
      logic       fixed;
      byte_type   rdata;
      logic       irq;
   } script_row_type;

   typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_style_type;
   typedef enum {SEQ_VRAM_WRITE, SEQ_VRAM_READ, SEQ_STEP, SEQ_DMA, SEQ_STATUS,
                 SEQ_NOISE, SEQ_BROKEN} seq_kind_type;

   logic clock = 1'b0;
   logic reset;

   vcvpd_req_if req_bus ();
   vcvpd_rsp_if rsp_bus ();

   video_ctrl_vram_port_dma_core #(
      .VRAM_ADDR_BITS(VRAM_ADDR_BITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Port model: VRAM, register file and the status and interrupt flags
   // --------------------------------------------------------------------------
   word_type   vram_model [0:VRAM_WORDS-1];
   word_type   regs_model [0:31];
   regsel_type sel_model;
   logic       done_model;
   logic       irq_model;
   byte_type   step_model;
   byte_type   low_hold_model;

   port_reply_type pending_replies [$];

   int           mismatches = 0;
   int           stim_count = 0;
   int           burst_left = 0;
   int           big_dma_left = BIG_DMA_RUNS;
   word_type     write_base = '0;
   int           idle_cycles = 0;
   rx_style_type rx_style = RX_OPEN;
   int           rx_phase_left = 0;
   int           rx_tick = 0;

   // Apply one bus access to the model and return the reply it produces.
   function automatic void vdc_port_reply(input logic m, input offset_type o,
                                          input byte_type d,
                                          output port_reply_type reply);
      word_type                  w;
      byte_type                  status;
      logic [VRAM_ADDR_BITS-1:0] src;
      logic [VRAM_ADDR_BITS-1:0] dst;
      logic                      hi;
      int unsigned               count;

      reply.rdata = RDATA_NONE;
      hi          = (o == OFS_DATA_HI);
      if (m == MODE_READ) begin
         if (o == OFS_SELECT) begin
            // status read clears both the done flag and the interrupt
            status                  = '0;
            status[STATUS_DONE_BIT] = done_model;
            reply.rdata             = status;
            done_model              = 1'b0;
            irq_model               = 1'b0;
         end else if (o != OFS_UNUSED && sel_model == REG_VRAM_DATA) begin
            w = vram_model[regs_model[REG_VRAM_RD_ADDR][VRAM_ADDR_BITS-1:0]];
            if (hi) begin
               reply.rdata                  = w[15:8];
               regs_model[REG_VRAM_RD_ADDR] = regs_model[REG_VRAM_RD_ADDR] + step_model;
            end else begin
               reply.rdata = w[7:0];
            end
         end
      end else if (o == OFS_SELECT) begin
         sel_model = d[4:0];
      end else if (o != OFS_UNUSED) begin
         if (hi) begin
            regs_model[sel_model][15:8] = d;
         end else begin
            regs_model[sel_model][7:0] = d;
         end
         if (sel_model == REG_VRAM_DATA) begin
            if (hi) begin
               vram_model[regs_model[REG_VRAM_WR_ADDR][VRAM_ADDR_BITS-1:0]] =
                  {d, low_hold_model};
               regs_model[REG_VRAM_WR_ADDR] = regs_model[REG_VRAM_WR_ADDR] + step_model;
            end else begin
               low_hold_model = d;
            end
         end else if (sel_model == REG_STEP && hi) begin
            case (d[4:3])
               2'd0:    step_model = 8'd1;
               2'd1:    step_model = 8'd32;
               2'd2:    step_model = 8'd64;
               default: step_model = 8'd128;
            endcase
         end else if (sel_model == REG_DMA_LEN && hi) begin
            // block copy, word by word, each side walking its own direction
            src   = regs_model[REG_DMA_SRC][VRAM_ADDR_BITS-1:0];
            dst   = regs_model[REG_DMA_DST][VRAM_ADDR_BITS-1:0];
            count = regs_model[REG_DMA_LEN][DMA_LEN_BITS-1:0];
            count = count + 1;
            for (int unsigned i = 0; i < count; i++) begin
               vram_model[dst] = vram_model[src];
               src = regs_model[REG_DMA_CTL][DMA_CTL_SRC_DOWN] ? src - 1'b1 : src + 1'b1;
               dst = regs_model[REG_DMA_CTL][DMA_CTL_DST_DOWN] ? dst - 1'b1 : dst + 1'b1;
            end
            done_model = 1'b1;
            if (regs_model[REG_DMA_CTL][DMA_CTL_IRQ_EN]) begin
               irq_model = 1'b1;
            end
         end
      end
      reply.irq = irq_model;
   endfunction

   // --------------------------------------------------------------------------
   // Request side: bursts of back-to-back requests with random gaps between
   // --------------------------------------------------------------------------
   task automatic send_access(input logic m, input offset_type o, input byte_type d,
                              input logic fixed, input byte_type fixed_rdata,
                              input logic fixed_irq);
      port_reply_type reply;
      int             gap;

      @(negedge clock);
      if (burst_left == 0) begin
         // mostly short bursts, now and then a long run with no idling
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= m;
      req_bus.offset <= o;
      req_bus.wdata  <= d;
      // hold the request until the core takes it
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      vdc_port_reply(m, o, d, reply);
      if (fixed) begin
         reply.rdata = fixed_rdata;
         reply.irq   = fixed_irq;
      end
      pending_replies.push_back(reply);
      if (o != OFS_UNUSED) begin
         stim_count++;
      end
   endtask

   task automatic access(input logic m, input offset_type o, input byte_type d);
      send_access(m, o, d, 1'b0, 8'h00, 1'b0);
   endtask

   // random byte and bit helpers
   function automatic byte_type rand_byte();
      return byte_type'($urandom);
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // select byte for a register, with random junk in the ignored top bits
   function automatic byte_type sel_code(input regsel_type r);
      byte_type v;
      v      = rand_byte();
      v[4:0] = r;
      return v;
   endfunction

   // VRAM address: extremes, near the last write burst, or anywhere
   function automatic word_type pick_addr();
      word_type a;
      case ($urandom_range(0, 7))
         0:       a = 16'hFFFF;
         1:       a = 16'h0000;
         2, 3:    a = write_base + word_type'($urandom_range(0, 15));
         default: a = word_type'($urandom);
      endcase
      return a;
   endfunction

   // --------------------------------------------------------------------------
   // Response side: stall pattern changes style at the end of each phase of clock cycles
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rx_phase_left == 0) begin
         case ($urandom_range(0, 3))
            0:       rx_style = RX_OPEN;
            1:       rx_style = RX_RANDOM;
            2:       rx_style = RX_SPARSE;
            default: rx_style = RX_PERIODIC;
         endcase
         rx_phase_left = $urandom_range(20, 150);
      end
      rx_phase_left--;
      rx_tick++;
      case (rx_style)
         RX_OPEN:     rsp_bus.ready <= 1'b1;
         RX_RANDOM:   rsp_bus.ready <= rand_bit();
         RX_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_bus.ready <= (rx_tick % 7) < 3;
      endcase
   end

   // Compare each reply with the oldest prediction.
   always @(posedge clock) begin : check_replies
      port_reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: reply with nothing outstanding: rdata %02h irq %b",
                     $time, rsp_bus.rdata, rsp_bus.irq_line);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.rdata !== want.rdata) begin
               $display("%0t: rdata expected %02h actual %02h",
                        $time, want.rdata, rsp_bus.rdata);
               mismatches++;
            end
            if (rsp_bus.irq_line !== want.irq) begin
               $display("%0t: irq_line expected %b actual %b",
                        $time, want.irq, rsp_bus.irq_line);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: the clearing pass and a full-length DMA are the longest
   // stretches without a handshake on either channel.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      script_row_type script [$];
      seq_kind_type   kind;
      int             pick;
      int             n;
      word_type       addr;
      byte_type       b;
      logic           m;
      offset_type     o;

      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.mode   = MODE_READ;
      req_bus.offset = OFS_SELECT;
      req_bus.wdata  = '0;

      for (int i = 0; i < VRAM_WORDS; i++) begin
         vram_model[i] = '0;
      end
      for (int i = 0; i < 32; i++) begin
         regs_model[i] = '0;
      end
      sel_model      = '0;
      done_model     = 1'b0;
      irq_model      = 1'b0;
      step_model     = STEP_RESET;
      low_hold_model = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // status after reset, dead offset, reads with a non-data register
      script.push_back('{MODE_READ,  OFS_SELECT,  8'h00, 1'b1, 8'h00, 1'b0});
      script.push_back('{MODE_READ,  OFS_UNUSED,  8'h00, 1'b1, 8'hFF, 1'b0});
      script.push_back('{MODE_WRITE, OFS_UNUSED,  8'hFF, 1'b1, 8'hFF, 1'b0});
      script.push_back('{MODE_READ,  OFS_DATA_LO, 8'h00, 1'b1, 8'hFF, 1'b0});
      // select with junk in the top bits still lands on the write address
      script.push_back('{MODE_WRITE, OFS_SELECT,  8'hE0, 1'b1, 8'hFF, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_LO, 8'hFF, 1'b1, 8'hFF, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_HI, 8'hFF, 1'b1, 8'hFF, 1'b0});
      // word at the top of VRAM, then the address wraps to zero
      script.push_back('{MODE_WRITE, OFS_SELECT,  8'h02, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_LO, 8'h00, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_HI, 8'hFF, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_LO, 8'hA5, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_HI, 8'h5A, 1'b0, 8'h00, 1'b0});
      // DMA of three words, both sides counting down, destination through the
      // wrap, interrupt enabled; length high byte has its ignored top bit set
      script.push_back('{MODE_WRITE, OFS_SELECT,  8'h0F, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_LO, 8'h0E, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_SELECT,  8'h10, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_LO, 8'hFF, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_HI, 8'h7F, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_SELECT,  8'h12, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_LO, 8'h02, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_HI, 8'h80, 1'b0, 8'h00, 1'b0});
      // done flag shows once, and the read drops the interrupt
      script.push_back('{MODE_READ,  OFS_SELECT,  8'h00, 1'b1, 8'h10, 1'b0});
      script.push_back('{MODE_READ,  OFS_SELECT,  8'h00, 1'b1, 8'h00, 1'b0});
      // read back the word the DMA copied to address zero
      script.push_back('{MODE_WRITE, OFS_SELECT,  8'h02, 1'b1, 8'hFF, 1'b0});
      script.push_back('{MODE_READ,  OFS_DATA_LO, 8'h00, 1'b0, 8'h00, 1'b0});
      script.push_back('{MODE_READ,  OFS_DATA_HI, 8'h00, 1'b0, 8'h00, 1'b0});
      // largest step
      script.push_back('{MODE_WRITE, OFS_SELECT,  8'h05, 1'b1, 8'hFF, 1'b0});
      script.push_back('{MODE_WRITE, OFS_DATA_HI, 8'h18, 1'b1, 8'hFF, 1'b0});

      for (int i = 0; i < script.size(); i++) begin
         send_access(script[i].mode, script[i].ofs, script[i].data,
                     script[i].fixed, script[i].rdata, script[i].irq);
      end

      // Random part: mostly well-formed sequences with random content.
      stim_count = 0;
      while (stim_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 25)      kind = SEQ_VRAM_WRITE;
         else if (pick < 45) kind = SEQ_VRAM_READ;
         else if (pick < 52) kind = SEQ_STEP;
         else if (pick < 64) kind = SEQ_DMA;
         else if (pick < 72) kind = SEQ_STATUS;
         else if (pick < 88) kind = SEQ_NOISE;
         else                kind = SEQ_BROKEN;

         case (kind)
            SEQ_VRAM_WRITE: begin
               addr = pick_addr();
               write_base = addr;
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_VRAM_WR_ADDR));
               access(MODE_WRITE, OFS_DATA_LO, addr[7:0]);
               access(MODE_WRITE, OFS_DATA_HI, addr[15:8]);
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_VRAM_DATA));
               n = $urandom_range(1, 8);
               repeat (n) begin
                  access(MODE_WRITE, OFS_DATA_LO, rand_byte());
                  // now and then drop the high byte: no word written
                  if ($urandom_range(0, 9) != 0) begin
                     access(MODE_WRITE, OFS_DATA_HI, rand_byte());
                  end
               end
            end
            SEQ_VRAM_READ: begin
               addr = ($urandom_range(0, 1) == 0) ? write_base : pick_addr();
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_VRAM_RD_ADDR));
               access(MODE_WRITE, OFS_DATA_LO, addr[7:0]);
               access(MODE_WRITE, OFS_DATA_HI, addr[15:8]);
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_VRAM_DATA));
               n = $urandom_range(1, 8);
               repeat (n) begin
                  if ($urandom_range(0, 1) == 0) begin
                     access(MODE_READ, OFS_DATA_LO, rand_byte());
                  end
                  access(MODE_READ, OFS_DATA_HI, rand_byte());
               end
            end
            SEQ_STEP: begin
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_STEP));
               if ($urandom_range(0, 1) == 0) begin
                  access(MODE_WRITE, OFS_DATA_LO, rand_byte());
               end
               access(MODE_WRITE, OFS_DATA_HI, rand_byte());
            end
            SEQ_DMA: begin
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_DMA_CTL));
               access(MODE_WRITE, OFS_DATA_LO, rand_byte());
               if ($urandom_range(0, 3) == 0) begin
                  access(MODE_WRITE, OFS_DATA_HI, rand_byte());
               end
               addr = pick_addr();
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_DMA_SRC));
               access(MODE_WRITE, OFS_DATA_LO, addr[7:0]);
               access(MODE_WRITE, OFS_DATA_HI, addr[15:8]);
               addr = pick_addr();
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_DMA_DST));
               access(MODE_WRITE, OFS_DATA_LO, addr[7:0]);
               access(MODE_WRITE, OFS_DATA_HI, addr[15:8]);
               // keep lengths short; allow a few long runs, the first at
               // full length
               if (big_dma_left != 0 && $urandom_range(0, 7) == 0) begin
                  addr = (big_dma_left == BIG_DMA_RUNS) ? 16'hFFFF
                                                        : word_type'($urandom);
                  big_dma_left--;
               end else begin
                  addr        = '0;
                  addr[7:0]   = ($urandom_range(0, 3) == 0)
                                   ? rand_byte()
                                   : byte_type'($urandom_range(0, 15));
                  addr[15]    = rand_bit();
               end
               access(MODE_WRITE, OFS_SELECT, sel_code(REG_DMA_LEN));
               access(MODE_WRITE, OFS_DATA_LO, addr[7:0]);
               access(MODE_WRITE, OFS_DATA_HI, addr[15:8]);
               if ($urandom_range(0, 1) == 0) begin
                  access(MODE_READ, OFS_SELECT, rand_byte());
               end
            end
            SEQ_STATUS: begin
               repeat ($urandom_range(1, 2)) begin
                  access(MODE_READ, OFS_SELECT, rand_byte());
               end
            end
            SEQ_NOISE: begin
               repeat ($urandom_range(1, 4)) begin
                  m = rand_bit();
                  o = offset_type'($urandom_range(0, 3));
                  b = rand_byte();
                  // cap a stray DMA trigger at 256 words
                  if (m == MODE_WRITE && o == OFS_DATA_HI && sel_model == REG_DMA_LEN) begin
                     b[6:0] = '0;
                  end
                  access(m, o, b);
               end
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: begin
                     // high byte alone pairs with a stale low byte
                     access(MODE_WRITE, OFS_SELECT, sel_code(REG_VRAM_DATA));
                     access(MODE_WRITE, OFS_DATA_HI, rand_byte());
                  end
                  1: begin
                     // length low byte only: no transfer
                     access(MODE_WRITE, OFS_SELECT, sel_code(REG_DMA_LEN));
                     access(MODE_WRITE, OFS_DATA_LO, rand_byte());
                  end
                  default: begin
                     access(MODE_WRITE, OFS_SELECT, rand_byte());
                     access(MODE_READ, ($urandom_range(0, 1) == 0) ? OFS_DATA_LO
                                                                   : OFS_DATA_HI,
                            rand_byte());
                     access(rand_bit(), OFS_UNUSED, rand_byte());
                  end
               endcase
            end
         endcase
      end

      // drop valid and drain the outstanding replies
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/vcvpd_pkg.sv
rtl/vcvpd_ifs.sv
rtl/vcvpd_ram.sv
rtl/vcvpd_ctrl.sv
rtl/vcvpd_dpath.sv
rtl/video_ctrl_vram_port_dma_core.sv
rtl/vcvpd_checker.sv
bench/tb.sv
